/* design/ehd_pkg.sv */
// ehd_pkg: shared types and constants for the holy-day date calculator
// no dependencies; imported by ehd_front, ehd_back and the core top level

package ehd_pkg;

  localparam logic [11:0] YEAR_MIN = 12'd1583;

  localparam logic [2:0] EV_CARNIVAL    = 3'd0;
  localparam logic [2:0] EV_GOOD_FRIDAY = 3'd1;
  localparam logic [2:0] EV_EASTER      = 3'd2;
  localparam logic [2:0] EV_ASCENSION   = 3'd3;
  localparam logic [2:0] EV_WHITSUNTIDE = 3'd4;

  typedef struct packed {
    logic [8:0] doy;
    logic       leap;
  } ehd_entry_t;

  // offset from easter in days, two's complement on nine bits
  function automatic logic [8:0] event_offset(input logic [2:0] ev);
    logic [8:0] off;
    case (ev)
      EV_CARNIVAL:    off = 9'h1D1;
      EV_GOOD_FRIDAY: off = 9'h1FE;
      EV_EASTER:      off = 9'd0;
      EV_ASCENSION:   off = 9'd39;
      EV_WHITSUNTIDE: off = 9'd49;
      default:        off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

/* design/ehd_queue.sv */
// ehd_queue: small register queue between the front and back parts
// generic width and depth; no package dependency

module ehd_queue #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* design/ehd_front.sv */
// ehd_front: accepts a year, clamps it and computes the easter day of year
// six-stage pipeline of constant-reciprocal divisions; uses ehd_pkg

module ehd_front import ehd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [11:0] in_year,
  output logic       push,
  output ehd_entry_t push_data,
  input  logic       full
);

  logic       en;
  logic       s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r;

  logic [11:0] s1_year_r;
  logic [11:0] s2_year_r;
  logic [5:0]  s2_b_r;
  logic [7:0]  s2_q19_r;
  logic [4:0]  s3_a_r;
  logic [5:0]  s3_b_r;
  logic [6:0]  s3_c_r;
  logic [5:0]  s3_gq_r;
  logic        s3_leap_r;
  logic [8:0]  s4_s_r;
  logic [4:0]  s4_a_r;
  logic [6:0]  s4_c_r;
  logic [1:0]  s4_e_r;
  logic        s4_leap_r;
  logic [4:0]  s5_h_r;
  logic [4:0]  s5_a_r;
  logic [6:0]  s5_c_r;
  logic [1:0]  s5_e_r;
  logic        s5_leap_r;
  logic [4:0]  s6_h_r;
  logic [2:0]  s6_l_r;
  logic [4:0]  s6_a_r;
  logic        s6_leap_r;

  logic [11:0] year_clamp;
  logic [24:0] prod100;
  logic [27:0] prod19;
  logic [11:0] b100, c_w, q19x, a_w;
  logic        leap_w, f_w;
  logic [5:0]  gq_w;
  logic [13:0] gp;
  logic [9:0]  s_w;
  logic [20:0] hp;
  logic [8:0]  h_w;
  logic [6:0]  v_w, l_w;
  logic [14:0] lp;
  logic [9:0]  w_w;
  logic        m_w;
  logic [7:0]  n_w;

  assign en       = !s6_v_r || !full;
  assign in_stall = !en;
  assign push     = s6_v_r && !full;

  assign year_clamp = (in_year < YEAR_MIN) ? YEAR_MIN : in_year;

  // year / 100 and year / 19
  assign prod100 = 25'(s1_year_r) * 25'd5243;
  assign prod19  = 28'(s1_year_r) * 28'd55189;

  // remainders, leap rule, gregorian correction term
  assign b100   = 12'(s2_b_r) * 12'd100;
  assign c_w    = s2_year_r - b100;
  assign q19x   = 12'(s2_q19_r) * 12'd19;
  assign a_w    = s2_year_r - q19x;
  assign leap_w = (s2_year_r[1:0] == 2'b00) && ((c_w[6:0] != 7'd0) || (s2_b_r[1:0] == 2'b00));
  assign f_w    = (s2_b_r >= 6'd17);
  assign gq_w   = s2_b_r - 6'(f_w) + 6'd1;

  // epact sum
  assign gp  = 14'(s3_gq_r) * 14'd171;
  assign s_w = 10'(s3_a_r) * 10'd19 + 10'(s3_b_r) + 10'd15
             - 10'(s3_b_r[5:2]) - 10'(gp[13:9]);

  // sum mod 30
  assign hp  = 21'(s4_s_r) * 21'd2185;
  assign h_w = s4_s_r - 9'(hp[20:16]) * 9'd30;

  // weekday term mod 7
  assign v_w = 7'd32 + 7'({s5_e_r, 1'b0}) + 7'({s5_c_r[6:2], 1'b0})
             - 7'(s5_h_r) - 7'(s5_c_r[1:0]);
  assign lp  = 15'(v_w) * 15'd147;
  assign l_w = v_w - 7'(lp[13:10]) * 7'd7;

  // march/april date folds into one day-of-year formula
  assign w_w = 10'(s6_a_r) + 10'(s6_h_r) * 10'd11 + 10'(s6_l_r) * 10'd22;
  assign m_w = (w_w >= 10'd451);
  assign n_w = 8'd114 + 8'(s6_h_r) + 8'(s6_l_r) - (m_w ? 8'd7 : 8'd0);

  always_comb begin
    push_data.doy  = 9'(n_w) - 9'd33 + 9'(s6_leap_r);
    push_data.leap = s6_leap_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_year_r <= year_clamp;
      s2_year_r <= s1_year_r;
      s2_b_r    <= prod100[24:19];
      s2_q19_r  <= prod19[27:20];
      s3_a_r    <= a_w[4:0];
      s3_b_r    <= s2_b_r;
      s3_c_r    <= c_w[6:0];
      s3_gq_r   <= gq_w;
      s3_leap_r <= leap_w;
      s4_s_r    <= s_w[8:0];
      s4_a_r    <= s3_a_r;
      s4_c_r    <= s3_c_r;
      s4_e_r    <= s3_b_r[1:0];
      s4_leap_r <= s3_leap_r;
      s5_h_r    <= h_w[4:0];
      s5_a_r    <= s4_a_r;
      s5_c_r    <= s4_c_r;
      s5_e_r    <= s4_e_r;
      s5_leap_r <= s4_leap_r;
      s6_h_r    <= s5_h_r;
      s6_l_r    <= l_w[2:0];
      s6_a_r    <= s5_a_r;
      s6_leap_r <= s5_leap_r;
    end
  end

endmodule

/* design/ehd_back.sv */
// ehd_back: walks the five events of one queued year, one per cycle while out_stall is low
// converts day of year to month and day; uses ehd_pkg

module ehd_back import ehd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       entry_valid,
  input  ehd_entry_t entry,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_event_index,
  output logic [8:0] out_day_of_year,
  output logic [3:0] out_month_number,
  output logic [4:0] out_day_of_month,
  output logic       out_leap_flag,
  output logic       out_last_event
);

  logic       load;
  logic [2:0] ev_r, ev_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] ev_idx_r;
  logic [8:0] doy_r;
  logic [3:0] month_r;
  logic [4:0] dom_r;
  logic       leap_r;
  logic       last_r;

  logic [8:0] dn;
  logic [8:0] lp;
  logic [8:0] days_prior;
  logic [3:0] month_w;
  logic [8:0] dom_w;

  assign load = entry_valid && (!out_valid_r || !out_stall);
  assign pop  = load && (ev_r == EV_WHITSUNTIDE);

  assign dn = entry.doy + event_offset(ev_r);
  assign lp = 9'(entry.leap);

  always_comb begin
    if (dn <= 9'd31) begin
      month_w    = 4'd1;
      days_prior = 9'd0;
    end else if (dn <= 9'd59 + lp) begin
      month_w    = 4'd2;
      days_prior = 9'd31;
    end else if (dn <= 9'd90 + lp) begin
      month_w    = 4'd3;
      days_prior = 9'd59 + lp;
    end else if (dn <= 9'd120 + lp) begin
      month_w    = 4'd4;
      days_prior = 9'd90 + lp;
    end else if (dn <= 9'd151 + lp) begin
      month_w    = 4'd5;
      days_prior = 9'd120 + lp;
    end else begin
      month_w    = 4'd6;
      days_prior = 9'd151 + lp;
    end
  end

  assign dom_w = dn - days_prior;

  always_comb begin
    ev_nxt        = ev_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      ev_nxt        = (ev_r == EV_WHITSUNTIDE) ? EV_CARNIVAL : ev_r + 3'd1;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r        <= EV_CARNIVAL;
      out_valid_r <= 1'b0;
    end else begin
      ev_r        <= ev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_idx_r <= ev_r;
      doy_r    <= dn;
      month_r  <= month_w;
      dom_r    <= dom_w[4:0];
      leap_r   <= entry.leap;
      last_r   <= (ev_r == EV_WHITSUNTIDE);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_index  = ev_idx_r;
  assign out_day_of_year  = doy_r;
  assign out_month_number = month_r;
  assign out_day_of_month = dom_r;
  assign out_leap_flag    = leap_r;
  assign out_last_event   = last_r;

endmodule

/* design/easter_holy_day_dates_core.sv */
// easter_holy_day_dates_core: top level of the holy-day date calculator
// instantiates ehd_front, ehd_queue and ehd_back; uses ehd_pkg
//
//   port group | direction | transaction
//   in_*       | input     | one year (in_year)
//   out_*      | output    | one event: index, day of year, month, day, leap, last
//
// a year yields five transactions on out_*, one per cycle while out_stall stays low;
// the back part pops a year from the queue with its last event, and its single output
// register sets that rate. out_valid rises once a year has passed the six front stages,
// the queue and the back output register. rst_n is synchronous and clears all valid bits,
// queue pointers and the event counter. out_stall holds the output register; in_stall
// rises once the queue holds QUEUE_DEPTH years and the last front stage is full.

module easter_holy_day_dates_core import ehd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_year,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_index,
  output logic [8:0]  out_day_of_year,
  output logic [3:0]  out_month_number,
  output logic [4:0]  out_day_of_month,
  output logic        out_leap_flag,
  output logic        out_last_event
);

  logic       q_push, q_full, q_pop, q_empty;
  ehd_entry_t q_wdata, q_rdata;

  ehd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_year   (in_year),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full)
  );

  ehd_queue #(
    .WIDTH ($bits(ehd_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  ehd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .entry_valid      (!q_empty),
    .entry            (q_rdata),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_index  (out_event_index),
    .out_day_of_year  (out_day_of_year),
    .out_month_number (out_month_number),
    .out_day_of_month (out_day_of_month),
    .out_leap_flag    (out_leap_flag),
    .out_last_event   (out_last_event)
  );

endmodule
